/* sv/windowed_mean_and_sum_assert.svh */
// Assertion macros for the windowed mean and sum block.
// Included by RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef WINDOWED_MEAN_AND_SUM_ASSERT_SVH
`define WINDOWED_MEAN_AND_SUM_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WMS_ASSERT_NOW(lbl, en, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cons)) \
    else $error("wms check failed");
// next-cycle implication
`define WMS_ASSERT_NEXT(lbl, en, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cons)) \
    else $error("wms check failed");
`else
`define WMS_ASSERT_NOW(lbl, en, cons)
`define WMS_ASSERT_NEXT(lbl, en, cons)
`endif
`endif

/* sv/wms_pkg.sv */
// Shared constants, types and helpers for the windowed mean and sum block.
// No dependencies; imported by the ALU, the divider and the top module of the block.
package wms_pkg;

  localparam int VAL_W          = 40;
  localparam int SAMPLE_W       = 32;
  localparam int WL_W           = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 9;
  localparam int MAX_WINDOW_DEF = 256;

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(5);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 1'b1;

  // output_mode codes
  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_SUM  = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sign-extend a sample into the accumulator width
  function automatic logic [VAL_W-1:0] widen(input logic [SAMPLE_W-1:0] s);
    widen = {{(VAL_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

endpackage

/* sv/wms_ram.sv */
// Generic single-port RAM with registered read (read-first).
// Depends on nothing; used for the sample history ring.
module wms_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/wms_alu.sv */
// Shared wide add/subtract unit used by the sequencer for all accumulator work.
// Depends on wms_pkg only for the default width VAL_W; purely combinational.
module wms_alu
  import wms_pkg::*;
#(
  parameter int W = VAL_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y
);

  logic [W-1:0] b_x;

  assign b_x = sub ? ~b : b;
  assign y   = a + b_x + W'(sub);

endmodule

/* sv/wms_div.sv */
// Restoring divider, one quotient bit per cycle: unsigned dividend by small divisor.
// Depends on wms_pkg (div_ctrl_t, div_stat_t).
module wms_div
  import wms_pkg::*;
#(
  parameter int DW    = VAL_W,
  parameter int LEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctrl,
  input  logic [DW-1:0]    dividend,
  input  logic [LEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DW-1:0]    quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    q_r, q_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [LEN_W:0]   shifted, diff;
  logic             ge;

  assign shifted = {rem_r, q_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctrl.start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CW'(1));
  assign quotient  = q_r;

endmodule

/* sv/windowed_mean_and_sum.sv */
// Windowed mean and sum: moving average over signed Q16.16 samples.
// Input channel in_valid/in_stall carries in_sample and in_sample_ok; one word
// in gives exactly one word out on out_valid/out_stall (out_value, out_value_ok).
// out_value_ok is high only when every slot of the window holds a valid sample;
// otherwise out_value is zero. output_mode selects mean (truncated toward zero)
// or sum. Config port cfg_valid/cfg_ready writes window_length (index 0) or
// output_mode (index 1); writing window_length empties the window. A pending
// config write holds in_stall high, so it lands before the next input word.
// A sum or a result that is not valid passes the read, add and output states;
// a mean also passes the magnitude step, the 40-step restoring divider and
// the sign fix. in_stall is high while an item is in flight, so a new word
// is taken only after the sequencer has returned to idle. A finished
// word sits in the output register, so a new item is accepted while the
// receiver stalls; the next result then waits until the output register
// drains. Reset (rst_n low, synchronous) empties the window, sets
// window_length to 5 and output_mode to mean. The history RAM is never swept:
// a fill count marks which ring slots were written since the last clear.
module windowed_mean_and_sum
  import wms_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_sample_ok,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_W-1:0]     out_value,
  output logic                        out_value_ok,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

`include "windowed_mean_and_sum_assert.svh"

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_RW = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W  = (LEN_RW < WL_W) ? LEN_RW : WL_W;
  localparam int RAM_W  = SAMPLE_W + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // old slot read back, retire it
  localparam logic [2:0] S_ADD  = 3'd2;  // add new sample, write slot
  localparam logic [2:0] S_ABS  = 3'd3;  // magnitude, launch divider
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;  // restore sign of quotient
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [WL_W-1:0]     wl_r, wl_nxt;
  logic                mode_r, mode_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       cur_pos_r, cur_pos_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    total_r, total_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic                smp_ok_r, smp_ok_nxt;
  logic                neg_r, neg_nxt;
  logic [VAL_W-1:0]    res_r, res_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic [LEN_W-1:0]    len_c;
  logic [AW-1:0]       pos_eff;
  logic [AW:0]         pos_inc;
  logic                in_acc, cfg_acc, out_free;
  logic                old_ok;
  logic [LEN_W-1:0]    cnt_add;

  // shared wide adder
  logic [VAL_W-1:0]    alu_a, alu_b, alu_y;
  logic                alu_sub;

  // history RAM
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [RAM_W-1:0]    ram_wdata, ram_rdata;

  // divider
  div_ctrl_t           div_ctrl;
  div_stat_t           div_stat;
  logic [VAL_W-1:0]    div_q;

  // effective window length: zero acts as one, clamp at MAX_WINDOW
  always_comb begin
    if (wl_r == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(wl_r) > MAX_WINDOW) begin
      len_c = LEN_W'(MAX_WINDOW);
    end else begin
      len_c = LEN_W'(wl_r);
    end
  end

  assign pos_eff  = (32'(pos_r) >= 32'(len_c)) ? '0 : pos_r;
  assign pos_inc  = (AW+1)'(cur_pos_r) + (AW+1)'(1);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;
  // slots past the fill count were never written since the last clear
  assign old_ok   = ram_rdata[SAMPLE_W] && (32'(cur_pos_r) < 32'(fill_r));
  assign cnt_add  = cnt_r + LEN_W'(smp_ok_r);

  // a config write in idle goes first; the input word waits while cfg_valid is high
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  assign ram_we    = (state_r == S_ADD);
  assign ram_addr  = (state_r == S_IDLE) ? pos_eff : cur_pos_r;
  assign ram_wdata = {smp_ok_r, smp_r};

  always_comb begin
    alu_a   = total_r;
    alu_b   = widen(smp_r);
    alu_sub = 1'b0;
    case (state_r)
      S_RD: begin
        alu_b   = widen(ram_rdata[SAMPLE_W-1:0]);
        alu_sub = 1'b1;
      end
      S_ABS: begin
        alu_a   = '0;
        alu_b   = total_r;
        alu_sub = 1'b1;
      end
      S_FIX: begin
        alu_a   = '0;
        alu_b   = div_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    cur_pos_nxt   = cur_pos_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    smp_nxt       = smp_r;
    smp_ok_nxt    = smp_ok_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    res_ok_nxt    = res_ok_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_ctrl      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_nxt     = in_sample;
          smp_ok_nxt  = in_sample_ok;
          cur_pos_nxt = pos_eff;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        if (old_ok) begin
          total_nxt = alu_y;
          cnt_nxt   = cnt_r - LEN_W'(1);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (smp_ok_r) begin
          total_nxt = alu_y;
        end
        cnt_nxt = cnt_add;
        pos_nxt = (32'(pos_inc) >= 32'(len_c)) ? '0 : pos_inc[AW-1:0];
        if (fill_r < len_c) begin
          fill_nxt = fill_r + LEN_W'(1);
        end
        if (cnt_add != len_c) begin
          res_nxt    = '0;
          res_ok_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else if (mode_r == MODE_SUM) begin
          res_nxt    = smp_ok_r ? alu_y : total_r;
          res_ok_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        neg_nxt        = total_r[VAL_W-1];
        div_ctrl.start = 1'b1;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        res_nxt    = neg_r ? alu_y : div_q;
        res_ok_nxt = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_value_nxt = res_r;
          out_ok_nxt    = res_ok_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          wl_nxt    = cfg_data[WL_W-1:0];
          pos_nxt   = '0;
          fill_nxt  = '0;
          cnt_nxt   = '0;
          total_nxt = '0;
        end
        REG_OUTPUT_MODE: begin
          mode_nxt = cfg_data[0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WL_RESET;
      mode_r      <= MODE_MEAN;
      pos_r       <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_pos_r   <= cur_pos_nxt;
    smp_r       <= smp_nxt;
    smp_ok_r    <= smp_ok_nxt;
    neg_r       <= neg_nxt;
    res_r       <= res_nxt;
    res_ok_r    <= res_ok_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  wms_alu #(
    .W (VAL_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  wms_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  wms_div #(
    .DW    (VAL_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (total_r[VAL_W-1] ? alu_y : total_r),
    .divisor  (len_c),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_value_ok = out_ok_r;

  `WMS_ASSERT_NOW(a_cnt_in_len, 1'b1, cnt_r <= len_c)
  `WMS_ASSERT_NOW(a_fill_in_len, 1'b1, fill_r <= len_c)
  `WMS_ASSERT_NEXT(a_accept_reads, in_acc, state_r == S_RD)
  `WMS_ASSERT_NOW(a_div_only_in_div, div_stat.busy, state_r == S_DIV)
  `WMS_ASSERT_NOW(a_missing_is_zero, out_valid_r && !out_ok_r, out_value_r == '0)

endmodule
